>>> src/rncvc_pkg.sv
// Package: constants, types and reference table for the colour vote classifier.
package rncvc_pkg;

  localparam int unsigned NumClasses    = 6;
  localparam int unsigned NumChannels   = 3;
  localparam int unsigned WindowSamples = 10;

  localparam int unsigned LevelWidth = 16;
  localparam int unsigned DiffWidth  = LevelWidth + 1;
  localparam int unsigned DistWidth  = DiffWidth + 2;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned RefWidth   = 9;

  typedef logic [2:0]            class_t;
  typedef logic [LevelWidth-1:0] level_t;
  typedef logic [DiffWidth-1:0]  diff_t;
  typedef logic [DistWidth-1:0]  dist_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [RefWidth-1:0]   ref_lvl_t;

  localparam class_t ClassRed    = 3'd0;
  localparam class_t ClassGreen  = 3'd1;
  localparam class_t ClassYellow = 3'd2;
  localparam class_t ClassOrange = 3'd3;
  localparam class_t ClassViolet = 3'd4;
  localparam class_t ClassNone   = 3'd5;

  localparam class_t TargetReset = ClassNone;

  // Reference colours, channel order red, green, blue.
  localparam ref_lvl_t RefColor [NumClasses][NumChannels] = '{
    '{9'd146, 9'd134, 9'd140},
    '{9'd138, 9'd187, 9'd155},
    '{9'd275, 9'd242, 9'd171},
    '{9'd233, 9'd158, 9'd152},
    '{9'd115, 9'd129, 9'd135},
    '{9'd143, 9'd164, 9'd164}
  };

  function automatic diff_t abs_diff(level_t lvl, ref_lvl_t ref_lvl);
    diff_t a;
    diff_t b;
    a = {1'b0, lvl};
    b = diff_t'(ref_lvl);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> src/rgb_nearest_color_vote_classifier_unit.sv
// Top level: nearest reference colour classifier with windowed majority vote.
//
// Accepts one RGB reading per cycle while the output is not stalled and returns
// one result per reading via the input and output registers. The input register
// feeds a single stage that forms six L1 distances, picks the nearest reference
// (ties to the earlier colour), updates the per-class vote counters and, on the
// tenth reading of a window, tallies the votes into the window colour and
// clears the counters. Throughput is one item per cycle when the output is not
// stalled, set by that single classify-and-vote stage. The target colour register
// resets to none and should only be written while no item is in flight.
module rgb_nearest_color_vote_classifier_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [47:0]          s_axis_tdata_i,  // red_level, green_level, blue_level
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,  // sample_class, final_color, to_target, pad
  output logic                 m_axis_tlast_o,  // vote_done
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  rncvc_pkg::class_t    cfg_data_i       // target_color
);
  import rncvc_pkg::*;

  logic   in_valid_q;
  level_t red_q, green_q, blue_q;
  logic   out_valid_q;
  class_t class_q, final_q;
  logic   done_q, hit_q;
  class_t target_q;
  count_t votes_q [NumClasses];
  count_t pos_q;

  logic   out_load, in_load;
  dist_t  l1_dist [NumClasses];
  class_t class_d, final_d;
  logic   done_d, hit_d;
  count_t votes_d [NumClasses];
  count_t pos_d;

  assign out_load        = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || out_load;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    logic   best, wins;
    count_t pos_inc;
    for (int k = 0; k < NumClasses; k++) begin
      l1_dist[k] = dist_t'(abs_diff(red_q, RefColor[k][0]))
                 + dist_t'(abs_diff(green_q, RefColor[k][1]))
                 + dist_t'(abs_diff(blue_q, RefColor[k][2]));
    end
    class_d = ClassNone;
    for (int k = NumClasses - 2; k >= 0; k--) begin
      best = 1'b1;
      for (int m = k + 1; m < NumClasses; m++) begin
        if (l1_dist[k] > l1_dist[m]) best = 1'b0;
      end
      if (best) class_d = class_t'(k);
    end

    for (int k = 0; k < NumClasses; k++) begin
      votes_d[k] = votes_q[k] + count_t'(class_d == class_t'(k));
    end

    final_d = ClassNone;
    for (int k = NumClasses - 2; k >= 0; k--) begin
      wins = 1'b1;
      for (int m = k + 1; m < NumClasses; m++) begin
        if (!(votes_d[k] > votes_d[m])) wins = 1'b0;
      end
      if (wins) final_d = class_t'(k);
    end

    pos_inc = pos_q + count_t'(1);
    done_d  = (pos_inc >= count_t'(WindowSamples));
    pos_d   = done_d ? '0 : pos_inc;
    if (!done_d) final_d = ClassRed;
    hit_d = done_d && (final_d == target_q);
    if (done_d) begin
      for (int k = 0; k < NumClasses; k++) votes_d[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      target_q    <= TargetReset;
      pos_q       <= '0;
      for (int k = 0; k < NumClasses; k++) votes_q[k] <= '0;
    end else begin
      if (cfg_valid_i) target_q <= cfg_data_i;
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (!out_valid_q || m_axis_tready_i) out_valid_q <= in_valid_q;
      if (out_load) begin
        pos_q <= pos_d;
        for (int k = 0; k < NumClasses; k++) votes_q[k] <= votes_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      red_q   <= s_axis_tdata_i[15:0];
      green_q <= s_axis_tdata_i[31:16];
      blue_q  <= s_axis_tdata_i[47:32];
    end
    if (out_load) begin
      class_q <= class_d;
      final_q <= final_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, hit_q, final_q, class_q};
  assign m_axis_tlast_o  = done_q;

endmodule
